// ===== rtl/sfbx_pkg.sv =====
// ----------------------------------------------------------------------------
// sfbx_pkg
// Shared types and constants for the serial frame builder with XOR check.
// ----------------------------------------------------------------------------
package sfbx_pkg;

  localparam logic [7:0] StartByte = 8'hB1;
  localparam logic [7:0] CheckSeed = 8'hFF;
  localparam logic [7:0] HdrExtra  = 8'd5;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ERROR   = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  // Byte positions inside one queued word.
  typedef enum logic [2:0] {
    POS_0 = 3'd0,
    POS_1 = 3'd1,
    POS_2 = 3'd2,
    POS_3 = 3'd3,
    POS_4 = 3'd4,
    POS_5 = 3'd5,
    POS_6 = 3'd6
  } pos_e;

  typedef struct packed {
    logic       op;
    logic [7:0] option;
    logic [7:0] cmd_id;
    logic [7:0] frame_type;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
    logic       error;
  } out_word_t;

  typedef struct packed {
    kind_e      kind;
    logic       close;
    logic [7:0] frame_len;
    logic [7:0] option;
    logic [7:0] cmd_id;
    logic [7:0] frame_type;
    logic [7:0] data;
    logic [7:0] seq;
    logic [7:0] check;
  } desc_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage

// ===== rtl/sfbx_front.sv =====
// ----------------------------------------------------------------------------
// sfbx_front
// Accepts input words, tracks frame state and emits one descriptor per word.
// ----------------------------------------------------------------------------
module sfbx_front #(
  parameter int unsigned MAX_PAYLOAD = 43
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfbx_pkg::in_word_t in_word_i,
  input  logic              q_full_i,
  output logic              push_o,
  output sfbx_pkg::desc_t   desc_o
);

  localparam logic [5:0] MaxLen = 6'(MAX_PAYLOAD);

  logic       in_payload_q, in_payload_d;
  logic [5:0] bytes_left_q, bytes_left_d;
  logic [7:0] check_acc_q, check_acc_d;
  logic [7:0] seq_q, seq_d;

  logic       accept;
  logic [5:0] bl_dec;
  logic [7:0] acc_next;
  sfbx_pkg::desc_t desc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign bl_dec     = bytes_left_q - 6'd1;

  always_comb begin
    in_payload_d = in_payload_q;
    bytes_left_d = bytes_left_q;
    check_acc_d  = check_acc_q;
    seq_d        = seq_q;
    acc_next     = check_acc_q;
    desc            = '0;
    desc.kind       = sfbx_pkg::KIND_ERROR;
    desc.frame_len  = {2'b00, in_word_i.payload_length} + sfbx_pkg::HdrExtra;
    desc.option     = in_word_i.option;
    desc.cmd_id     = in_word_i.cmd_id;
    desc.frame_type = in_word_i.frame_type;
    desc.data       = in_word_i.payload_byte;
    desc.seq        = seq_q;
    if (in_word_i.op == sfbx_pkg::OP_BEGIN) begin
      if (in_word_i.payload_length <= MaxLen) begin
        desc.kind = sfbx_pkg::KIND_HEADER;
        acc_next  = sfbx_pkg::CheckSeed ^ in_word_i.option ^ in_word_i.cmd_id
                    ^ in_word_i.frame_type;
        if (in_word_i.payload_length == 6'd0) begin
          desc.close = 1'b1;
        end else begin
          in_payload_d = 1'b1;
          bytes_left_d = in_word_i.payload_length;
          check_acc_d  = acc_next;
        end
      end
    end else if (in_payload_q) begin
      desc.kind = sfbx_pkg::KIND_PAYLOAD;
      acc_next  = check_acc_q ^ in_word_i.payload_byte;
      if (bl_dec == 6'd0) begin
        desc.close = 1'b1;
      end else begin
        bytes_left_d = bl_dec;
        check_acc_d  = acc_next;
      end
    end
    desc.check = acc_next ^ seq_q;
    if (desc.close) begin
      in_payload_d = 1'b0;
      bytes_left_d = 6'd0;
      check_acc_d  = sfbx_pkg::CheckSeed;
      seq_d        = seq_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      bytes_left_q <= 6'd0;
      check_acc_q  <= sfbx_pkg::CheckSeed;
      seq_q        <= 8'd0;
    end else if (accept) begin
      in_payload_q <= in_payload_d;
      bytes_left_q <= bytes_left_d;
      check_acc_q  <= check_acc_d;
      seq_q        <= seq_d;
    end
  end

  assign push_o = accept;
  assign desc_o = desc;

endmodule

// ===== rtl/sfbx_fifo.sv =====
// ----------------------------------------------------------------------------
// sfbx_fifo
// Small descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
module sfbx_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfbx_pkg::q_ctl_t ctl_i,
  input  sfbx_pkg::desc_t  wr_desc_i,
  output sfbx_pkg::desc_t  rd_desc_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = sfbx_pkg::QueuePtrW;
  localparam int unsigned CntW = sfbx_pkg::QueueCntW;

  sfbx_pkg::desc_t mem_q [sfbx_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = count_q == CntW'(sfbx_pkg::QueueDepth);
  assign empty_o   = count_q == '0;
  assign do_push   = ctl_i.push && !full_o;
  assign do_pop    = ctl_i.pop && !empty_o;
  assign rd_desc_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/sfbx_back.sv =====
// ----------------------------------------------------------------------------
// sfbx_back
// Serializes queued descriptors into output bytes through an output register.
// ----------------------------------------------------------------------------
module sfbx_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfbx_pkg::desc_t    head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sfbx_pkg::out_word_t out_word_o
);

  logic [2:0]          pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  sfbx_pkg::out_word_t out_word_q, out_word_d;
  logic                load;
  logic [2:0]          last_pos;
  logic [7:0]          cur_byte;
  logic                cur_end;
  logic                cur_err;

  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    last_pos = sfbx_pkg::POS_0;
    cur_byte = 8'd0;
    cur_end  = 1'b0;
    cur_err  = 1'b0;
    case (head_i.kind)
      sfbx_pkg::KIND_HEADER: begin
        last_pos = head_i.close ? sfbx_pkg::POS_6 : sfbx_pkg::POS_4;
        case (pos_q)
          sfbx_pkg::POS_0: cur_byte = sfbx_pkg::StartByte;
          sfbx_pkg::POS_1: cur_byte = head_i.frame_len;
          sfbx_pkg::POS_2: cur_byte = head_i.option;
          sfbx_pkg::POS_3: cur_byte = head_i.cmd_id;
          sfbx_pkg::POS_4: cur_byte = head_i.frame_type;
          sfbx_pkg::POS_5: cur_byte = head_i.seq;
          default: begin
            cur_byte = head_i.check;
            cur_end  = 1'b1;
          end
        endcase
      end
      sfbx_pkg::KIND_PAYLOAD: begin
        last_pos = head_i.close ? sfbx_pkg::POS_2 : sfbx_pkg::POS_0;
        case (pos_q)
          sfbx_pkg::POS_0: cur_byte = head_i.data;
          sfbx_pkg::POS_1: cur_byte = head_i.seq;
          default: begin
            cur_byte = head_i.check;
            cur_end  = 1'b1;
          end
        endcase
      end
      default: begin
        cur_err = 1'b1;
      end
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d          = 1'b1;
      out_word_d.out_byte  = cur_byte;
      out_word_d.frame_end = cur_end;
      out_word_d.error     = cur_err;
      out_word_d.run_last  = pos_q == last_pos;
      if (pos_q == last_pos) begin
        pos_d = sfbx_pkg::POS_0;
        pop_o = 1'b1;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= sfbx_pkg::POS_0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/serial_frame_builder_xor_top.sv =====
// ----------------------------------------------------------------------------
// serial_frame_builder_xor_top
// Serial frame builder: header, payload, sequence number and XOR check byte.
// ----------------------------------------------------------------------------
// An input word is taken whenever the four-entry descriptor queue has room,
// so words can arrive back to back. Output leaves one byte per cycle from the
// output register while out_ready_i is high and the queue holds a descriptor,
// and that port sets the sustained rate: a begin word yields 5 bytes (7 when
// the payload is empty), a payload word 1 byte (3 on the last byte of a frame),
// a rejected word 1 byte. No clearing pass follows reset.
module serial_frame_builder_xor_top #(
  parameter int unsigned MAX_PAYLOAD = 43
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfbx_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfbx_pkg::out_word_t out_word_o
);

  sfbx_pkg::q_ctl_t q_ctl;
  sfbx_pkg::desc_t  wr_desc;
  sfbx_pkg::desc_t  head;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;

  assign q_ctl = '{push: q_push, pop: q_pop};

  sfbx_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .desc_o     (wr_desc)
  );

  sfbx_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (q_ctl),
    .wr_desc_i (wr_desc),
    .rd_desc_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  sfbx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_end |-> out_word_o.run_last && !out_word_o.error)
    else $error("check byte not closing its word");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.error |-> out_word_o.run_last && out_word_o.out_byte == 8'd0)
    else $error("error result malformed");

  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !q_pop)
    else $error("pop from empty queue");

endmodule

// ===== dv/tb_serial_frame_builder_xor_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_frame_builder_xor_top
// Self-checking bench for the serial frame builder. Input words and output
// bytes use random gaps and stalls, plus one long output hold-off. Each
// accepted word is run through a local frame model, and every output byte is
// compared field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_serial_frame_builder_xor_top;

  localparam int unsigned MaxPayload = 43;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandWords  = 92;
  localparam int unsigned InWordW    = $bits(sfbx_pkg::in_word_t);

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  sfbx_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sfbx_pkg::out_word_t out_word_o;

  sfbx_pkg::in_word_t  pending_words[$];
  sfbx_pkg::out_word_t expected_bytes[$];
  sfbx_pkg::out_word_t word_burst[$];

  // frame model state
  logic       frame_open = 1'b0;
  logic [5:0] bytes_due  = '0;
  logic [7:0] xor_acc    = sfbx_pkg::CheckSeed;
  logic [7:0] frame_seq  = '0;

  int   fail_count     = 0;
  int   words_accepted = 0;
  logic word_taken     = 1'b0;
  logic byte_taken     = 1'b0;
  int   send_gap       = 0;
  int   recv_stall     = 0;
  logic send_calm      = 1'b0;
  logic recv_calm      = 1'b0;
  logic recv_hold      = 1'b0;

  serial_frame_builder_xor_top #(
    .MAX_PAYLOAD(MaxPayload)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic sfbx_pkg::in_word_t begin_word(input logic [7:0] opt, id, typ,
                                                    input logic [5:0] len);
    sfbx_pkg::in_word_t w;
    w = InWordW'({$urandom, $urandom});
    w.op             = sfbx_pkg::OP_BEGIN;
    w.option         = opt;
    w.cmd_id         = id;
    w.frame_type     = typ;
    w.payload_length = len;
    return w;
  endfunction

  function automatic sfbx_pkg::in_word_t payload_word(input logic [7:0] b);
    sfbx_pkg::in_word_t w;
    w = InWordW'({$urandom, $urandom});
    w.op           = sfbx_pkg::OP_PAYLOAD;
    w.payload_byte = b;
    return w;
  endfunction

  task automatic emit_byte(input logic [7:0] b, input logic fin, input logic err);
    sfbx_pkg::out_word_t r;
    r.out_byte  = b;
    r.frame_end = fin;
    r.run_last  = 1'b0;
    r.error     = err;
    word_burst.push_back(r);
  endtask

  task automatic finish_frame();
    emit_byte(frame_seq, 1'b0, 1'b0);
    xor_acc = xor_acc ^ frame_seq;
    emit_byte(xor_acc, 1'b1, 1'b0);
    frame_seq  = frame_seq + 8'd1;
    frame_open = 1'b0;
    bytes_due  = '0;
    xor_acc    = sfbx_pkg::CheckSeed;
  endtask

  task automatic predict_frame_bytes(input sfbx_pkg::in_word_t w);
    sfbx_pkg::out_word_t r;
    word_burst.delete();
    if (w.op == sfbx_pkg::OP_BEGIN) begin
      if (w.payload_length > MaxPayload) begin
        emit_byte(8'h00, 1'b0, 1'b1);
      end else begin
        emit_byte(sfbx_pkg::StartByte, 1'b0, 1'b0);
        emit_byte({2'b00, w.payload_length} + sfbx_pkg::HdrExtra, 1'b0, 1'b0);
        emit_byte(w.option, 1'b0, 1'b0);
        emit_byte(w.cmd_id, 1'b0, 1'b0);
        emit_byte(w.frame_type, 1'b0, 1'b0);
        xor_acc = sfbx_pkg::CheckSeed ^ w.option ^ w.cmd_id ^ w.frame_type;
        if (w.payload_length == 6'd0) begin
          finish_frame();
        end else begin
          frame_open = 1'b1;
          bytes_due  = w.payload_length;
        end
      end
    end else if (!frame_open) begin
      emit_byte(8'h00, 1'b0, 1'b1);
    end else begin
      emit_byte(w.payload_byte, 1'b0, 1'b0);
      xor_acc   = xor_acc ^ w.payload_byte;
      bytes_due = bytes_due - 6'd1;
      if (bytes_due == 6'd0) finish_frame();
    end
    r = word_burst.pop_back();
    r.run_last = 1'b1;
    word_burst.push_back(r);
    while (word_burst.size() > 0) expected_bytes.push_back(word_burst.pop_front());
  endtask

  task automatic check_frame_byte(input sfbx_pkg::out_word_t got);
    sfbx_pkg::out_word_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected byte: expected none, got %h", $time, got);
      fail_count++;
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte: expected %h, got %h", $time, want.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.frame_end !== want.frame_end) begin
        $display("%0t: frame_end: expected %b, got %b", $time, want.frame_end,
                 got.frame_end);
        fail_count++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last: expected %b, got %b", $time, want.run_last, got.run_last);
        fail_count++;
      end
      if (got.error !== want.error) begin
        $display("%0t: error: expected %b, got %b", $time, want.error, got.error);
        fail_count++;
      end
    end
  endtask

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_frame_bytes(in_word_i);
        word_taken = 1'b1;
        words_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        check_frame_byte(out_word_o);
        byte_taken = 1'b1;
      end
    end
  end

  // driver: hold the word until taken, then wait out the gap
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && word_taken) begin
        word_taken = 1'b0;
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 10);
        if (send_gap == 0 && pending_words.size() > 0) begin
          in_word_i <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0) begin
          in_word_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // receiver: stall after each byte, drop ready during the hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 10);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !recv_hold;
      end
    end
  end

  initial begin
    while (words_accepted < 40) @(posedge clk_i);
    recv_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  initial begin
    #400000;
    $display("tb_serial_frame_builder_xor_top NOT OK");
    $finish;
  end

  initial begin
    int         rand_words;
    int         pick;
    int         len;
    int         count;
    logic       gen_open;
    logic       first_frame;
    logic [7:0] typ;

    pending_words.push_back(payload_word(8'hFF));
    pending_words.push_back(begin_word(8'h00, 8'h00, 8'h00, 6'd0));
    pending_words.push_back(begin_word(8'hFF, 8'hFF, 8'hFF, 6'd0));
    pending_words.push_back(begin_word(8'h01, 8'h02, 8'h01, 6'd63));
    pending_words.push_back(begin_word(8'h10, 8'h20, 8'h02, 6'd44));
    pending_words.push_back(begin_word(8'hA5, 8'h5A, 8'h02, 6'd1));
    pending_words.push_back(payload_word(8'h00));
    pending_words.push_back(begin_word(8'h3C, 8'hC3, 8'h01, 6'd2));
    pending_words.push_back(payload_word(8'hFF));
    pending_words.push_back(payload_word(8'h5A));
    // abandon a frame with a new begin
    pending_words.push_back(begin_word(8'h77, 8'h88, 8'h00, 6'd3));
    pending_words.push_back(payload_word(8'h11));
    pending_words.push_back(begin_word(8'h99, 8'hAA, 8'h01, 6'd0));
    // oversize begin inside an open frame
    pending_words.push_back(begin_word(8'h12, 8'h34, 8'h02, 6'd2));
    pending_words.push_back(payload_word(8'h55));
    pending_words.push_back(begin_word(8'h00, 8'h00, 8'h00, 6'd50));
    pending_words.push_back(payload_word(8'hAA));
    pending_words.push_back(payload_word(8'h01));

    rand_words  = 0;
    gen_open    = 1'b0;
    first_frame = 1'b1;
    while (rand_words < RandWords) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        len = $urandom_range(MaxPayload + 1, 63);
        pending_words.push_back(begin_word(8'($urandom), 8'($urandom), 8'($urandom),
                                           6'(len)));
        rand_words++;
      end else if (pick == 1 && !gen_open) begin
        pending_words.push_back(payload_word(8'($urandom)));
        rand_words++;
      end else begin
        if (first_frame) len = MaxPayload;
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(0, MaxPayload);
        else len = $urandom_range(0, 4);
        first_frame = 1'b0;
        typ = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        count = len;
        gen_open = 1'b0;
        if (pick == 2 && len > 0) begin
          count = $urandom_range(0, len - 1);
          gen_open = 1'b1;
        end
        pending_words.push_back(begin_word(8'($urandom), 8'($urandom), typ, 6'(len)));
        repeat (count) pending_words.push_back(payload_word(8'($urandom)));
        rand_words += count + 1;
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pending_words.size() > 0 || in_valid_i || expected_bytes.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (expected_bytes.size() > 0) begin
      $display("%0t: missing bytes: expected %0d more, got 0", $time,
               expected_bytes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_serial_frame_builder_xor_top OK");
    end else begin
      $display("tb_serial_frame_builder_xor_top NOT OK");
    end
    $finish;
  end

endmodule
